[sv/tlqe_pkg.sv]
// Shared types and constants for the thick line quad expander.
`timescale 1ns / 1ps
`default_nettype none
package tlqe_pkg;

    // Segment data that travels with each item down the pipeline.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [23:0]        depth;
        logic               degen;
        logic               negx;
        logic               negy;
    } t_side;

    localparam int unsigned DIR_FRAC  = 30;
    localparam int unsigned NUM_VERTS = 6;

    // Corner index for each vertex slot: p1, p4, p2, p4, p3, p2.
    function automatic logic [1:0] vert_corner(input logic [2:0] k);
        logic [1:0] c;
        case (k)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd3;
            3'd2:    c = 2'd1;
            3'd3:    c = 2'd3;
            3'd4:    c = 2'd2;
            default: c = 2'd1;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[sv/thick_line_quad_expander_top.sv]
// Top level of the thick line quad expander: segment in, six triangle vertices out.
// The first vertex of a segment is offered after the segment has passed through
// 70 pipeline stages and then the output register.
// The output port sends six vertices per segment and holds the core meanwhile.
// The core takes a new segment every cycle while the output register is free.
// Reset: synchronous, active low; clears all valid bits and the vertex counter,
// and sets stroke_width to 65536 (one pixel).
`timescale 1ns / 1ps
`default_nettype none
module thick_line_quad_expander_top
    import tlqe_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire         [23:0] i_cfg_wdata,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  signed [31:0] i_start_x,
    input  wire  signed [31:0] i_start_y,
    input  wire  signed [31:0] i_end_x,
    input  wire  signed [31:0] i_end_y,
    input  wire         [23:0] i_depth_in,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_vert_x,
    output logic signed [31:0] o_vert_y,
    output logic        [23:0] o_depth_out,
    output logic signed [31:0] o_seg_start_x,
    output logic signed [31:0] o_seg_start_y,
    output logic signed [31:0] o_seg_end_x,
    output logic signed [31:0] o_seg_end_y,
    output logic               o_last_vertex,
    output logic               o_degenerate
);

    // Stage map. The front end finds the deltas, normalizes them so the larger
    // magnitude has its leading one at bit 30, and forms the sum of squares.
    // The square root takes one result bit per stage, then two dividers run side
    // by side, one quotient bit per stage. The back end scales by half the stroke
    // width, applies signs and forms the four saturated corners.
    localparam int S4   = 4;
    localparam int SQ0  = 6;
    localparam int SQN  = 32;
    localparam int DV0  = SQ0 + SQN;
    localparam int DVN  = 31;
    localparam int SM   = DV0 + DVN;
    localparam int SR   = SM + 1;
    localparam int NST  = SR;

    logic [NST:1] r_v;
    t_side        r_sd [1:NST];
    logic         en;

    logic [23:0]  r_stroke;

    // The whole pipeline advances together; it holds while the output register
    // still has vertices of an earlier item to send.
    logic          r_ob;
    logic [2:0]    r_k;
    assign en      = !r_ob || (i_ready && r_k == 3'(NUM_VERTS - 1));
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stroke <= 24'd65536;
        end else if (i_cfg_we) begin
            r_stroke <= i_cfg_wdata;
        end
    end

    // Front end, stage 1: deltas and their magnitudes.
    logic signed [32:0] n_dx, n_dy;
    logic        [32:0] r1_ax, r1_ay;
    always_comb begin
        n_dx = {i_end_x[31], i_end_x} - {i_start_x[31], i_start_x};
        n_dy = {i_end_y[31], i_end_y} - {i_start_y[31], i_start_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[1].sx    <= i_start_x;
            r_sd[1].sy    <= i_start_y;
            r_sd[1].ex    <= i_end_x;
            r_sd[1].ey    <= i_end_y;
            r_sd[1].depth <= i_depth_in;
            r_sd[1].degen <= (n_dx == '0) && (n_dy == '0);
            r_sd[1].negx  <= n_dx[32];
            r_sd[1].negy  <= n_dy[32];
            r1_ax         <= n_dx[32] ? 33'(-n_dx) : 33'(n_dx);
            r1_ay         <= n_dy[32] ? 33'(-n_dy) : 33'(n_dy);
            for (int s = 2; s <= NST; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // Stage 2: position of the leading one of the larger magnitude.
    logic [32:0] n_m;
    logic [5:0]  n_lead;
    logic [32:0] r2_ax, r2_ay;
    logic [5:0]  r2_lead;
    always_comb begin
        n_m    = (r1_ax > r1_ay) ? r1_ax : r1_ay;
        n_lead = '0;
        for (int i = 0; i < 33; i++) begin
            if (n_m[i]) n_lead = 6'(i);
        end
    end

    // Stage 3: normalizing shift, truncating on the right.
    logic [63:0] n_shx, n_shy;
    logic [30:0] r_nx [3:DV0-1];
    logic [30:0] r_ny [3:DV0-1];
    always_comb begin
        if (r2_lead > 6'(DIR_FRAC)) begin
            n_shx = 64'(r2_ax) >> (r2_lead - 6'(DIR_FRAC));
            n_shy = 64'(r2_ay) >> (r2_lead - 6'(DIR_FRAC));
        end else begin
            n_shx = 64'(r2_ax) << (6'(DIR_FRAC) - r2_lead);
            n_shy = 64'(r2_ay) << (6'(DIR_FRAC) - r2_lead);
        end
    end

    // Stages 4 and 5: squares, then their sum.
    logic [61:0] r4_sqx, r4_sqy;
    logic [63:0] r5_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_lead <= n_lead;
            r_nx[3] <= n_shx[30:0];
            r_ny[3] <= n_shy[30:0];
            for (int s = 4; s < DV0; s++) begin
                r_nx[s] <= r_nx[s-1];
                r_ny[s] <= r_ny[s-1];
            end
            r4_sqx  <= 62'(r_nx[3]) * 62'(r_nx[3]);
            r4_sqy  <= 62'(r_ny[3]) * 62'(r_ny[3]);
            r5_n    <= 64'(r4_sqx) + 64'(r4_sqy);
        end
    end

    // Square root, one result bit per stage.
    logic [34:0] r_sq_rem  [0:SQN];
    logic [31:0] r_sq_root [0:SQN];
    logic [63:0] r_sq_n    [0:SQN];
    assign r_sq_rem[0]  = '0;
    assign r_sq_root[0] = '0;
    assign r_sq_n[0]    = r5_n;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [34:0] n_rs, n_tr;
        always_comb begin
            n_rs = {r_sq_rem[k][32:0], r_sq_n[k][63-2*k -: 2]};
            n_tr = {1'b0, r_sq_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_n[k+1] <= r_sq_n[k];
                if (n_rs >= n_tr) begin
                    r_sq_rem[k+1]  <= n_rs - n_tr;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= n_rs;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b0};
                end
            end
        end
    end

    // Two restoring dividers: u = (a << 30) / len, one quotient bit per stage.
    logic [31:0] r_dx_rem [0:DVN];
    logic [31:0] r_dy_rem [0:DVN];
    logic [30:0] r_dx_q   [0:DVN];
    logic [30:0] r_dy_q   [0:DVN];
    logic [31:0] r_len    [0:DVN];
    logic        r_dx_b0  [0:DVN];
    logic        r_dy_b0  [0:DVN];
    assign r_dx_rem[0] = {2'b00, r_nx[DV0-1][30:1]};
    assign r_dy_rem[0] = {2'b00, r_ny[DV0-1][30:1]};
    assign r_dx_q[0]   = '0;
    assign r_dy_q[0]   = '0;
    assign r_len[0]    = r_sq_root[SQN];
    assign r_dx_b0[0]  = r_nx[DV0-1][0];
    assign r_dy_b0[0]  = r_ny[DV0-1][0];

    for (genvar k = 0; k < DVN; k++) begin : g_div
        logic [32:0] n_rx, n_ry;
        always_comb begin
            n_rx = {r_dx_rem[k], (k == 0) ? r_dx_b0[k] : 1'b0};
            n_ry = {r_dy_rem[k], (k == 0) ? r_dy_b0[k] : 1'b0};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_len[k+1]   <= r_len[k];
                r_dx_b0[k+1] <= 1'b0;
                r_dy_b0[k+1] <= 1'b0;
                if (n_rx >= {1'b0, r_len[k]}) begin
                    r_dx_rem[k+1] <= 32'(n_rx - {1'b0, r_len[k]});
                    r_dx_q[k+1]   <= {r_dx_q[k][29:0], 1'b1};
                end else begin
                    r_dx_rem[k+1] <= n_rx[31:0];
                    r_dx_q[k+1]   <= {r_dx_q[k][29:0], 1'b0};
                end
                if (n_ry >= {1'b0, r_len[k]}) begin
                    r_dy_rem[k+1] <= 32'(n_ry - {1'b0, r_len[k]});
                    r_dy_q[k+1]   <= {r_dy_q[k][29:0], 1'b1};
                end else begin
                    r_dy_rem[k+1] <= n_ry[31:0];
                    r_dy_q[k+1]   <= {r_dy_q[k][29:0], 1'b0};
                end
            end
        end
    end

    // Back end: scale by half the stroke width, round, sign, corners.
    logic [53:0]        rm_px, rm_py;
    logic [54:0]        n_rx, n_ry;
    logic signed [25:0] n_ox, n_oy;
    logic signed [25:0] rr_ox, rr_oy;
    logic signed [34:0] n_vx [0:3];
    logic signed [34:0] n_vy [0:3];
    logic signed [31:0] r_cx [0:3];
    logic signed [31:0] r_cy [0:3];
    t_side              r_osd;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    always_comb begin
        n_rx = 55'(rm_px) + (55'd1 << (DIR_FRAC - 1));
        n_ry = 55'(rm_py) + (55'd1 << (DIR_FRAC - 1));
        n_ox = $signed({1'b0, n_rx[54:30]});
        n_oy = $signed({1'b0, n_ry[54:30]});
        if (r_sd[SR-1].degen) begin
            n_ox = '0;
            n_oy = '0;
        end
        if (r_sd[SR-1].negx) n_ox = -n_ox;
        if (r_sd[SR-1].negy) n_oy = -n_oy;
    end

    always_comb begin
        n_vx[0] = 35'(r_sd[SR].sx) - 35'(rr_ox) + 35'(rr_oy);
        n_vy[0] = 35'(r_sd[SR].sy) - 35'(rr_oy) - 35'(rr_ox);
        n_vx[1] = 35'(r_sd[SR].ex) + 35'(rr_ox) + 35'(rr_oy);
        n_vy[1] = 35'(r_sd[SR].ey) + 35'(rr_oy) - 35'(rr_ox);
        n_vx[2] = 35'(r_sd[SR].ex) + 35'(rr_ox) - 35'(rr_oy);
        n_vy[2] = 35'(r_sd[SR].ey) + 35'(rr_oy) + 35'(rr_ox);
        n_vx[3] = 35'(r_sd[SR].sx) - 35'(rr_ox) - 35'(rr_oy);
        n_vy[3] = 35'(r_sd[SR].sy) - 35'(rr_oy) + 35'(rr_ox);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_px <= 54'(r_stroke[23:1]) * 54'(r_dx_q[DVN]);
            rm_py <= 54'(r_stroke[23:1]) * 54'(r_dy_q[DVN]);
            rr_ox <= n_ox;
            rr_oy <= n_oy;
            for (int c = 0; c < 4; c++) begin
                r_cx[c] <= sat32(n_vx[c]);
                r_cy[c] <= sat32(n_vy[c]);
            end
            r_osd <= r_sd[NST];
        end
    end

    // Output register: the last stage holds the four corners while the six
    // vertices go out, one per accepted handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= 1'b0;
            r_k  <= '0;
        end else if (en) begin
            r_ob <= r_v[NST];
            r_k  <= '0;
        end else if (i_ready) begin
            r_k  <= r_k + 3'd1;
        end
    end

    always_comb begin
        o_valid       = r_ob;
        o_vert_x      = r_cx[vert_corner(r_k)];
        o_vert_y      = r_cy[vert_corner(r_k)];
        o_depth_out   = r_osd.depth;
        o_seg_start_x = r_osd.sx;
        o_seg_start_y = r_osd.sy;
        o_seg_end_x   = r_osd.ex;
        o_seg_end_y   = r_osd.ey;
        o_last_vertex = (r_k == 3'(NUM_VERTS - 1));
        o_degenerate  = r_osd.degen;
    end

endmodule
`default_nettype wire

[sv/tlqe_checker.sv]
// Port-level assertions for the thick line quad expander and their bind.
`timescale 1ns / 1ps
`default_nettype none
module tlqe_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_valid,
    input wire               i_ready,
    input wire signed [31:0] o_vert_x,
    input wire signed [31:0] o_vert_y,
    input wire signed [31:0] o_seg_start_x,
    input wire signed [31:0] o_seg_start_y,
    input wire               o_last_vertex,
    input wire               o_degenerate
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vert_x) && $stable(o_vert_y))
        else $error("stalled item changed");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_vertex |=> o_valid)
        else $error("vertex burst broken before the last vertex");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_vert_x == o_seg_start_x && o_vert_y == o_seg_start_y)
        else $error("degenerate segment vertex differs from start point");

endmodule

bind thick_line_quad_expander_top tlqe_checker u_tlqe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_vert_x      (o_vert_x),
    .o_vert_y      (o_vert_y),
    .o_seg_start_x (o_seg_start_x),
    .o_seg_start_y (o_seg_start_y),
    .o_last_vertex (o_last_vertex),
    .o_degenerate  (o_degenerate)
);
`default_nettype wire

[tb/thick_line_quad_expander_top_tb.sv]
// Self-checking testbench for the thick line quad expander: directed and random segments in, vertices checked.
`timescale 1ns / 1ps
module thick_line_quad_expander_top_tb;
    import tlqe_pkg::*;

    // A segment as sent to the block.
    typedef struct {
        logic signed [31:0] sx, sy, ex, ey;
        logic [23:0]        depth;
    } t_segment;

    // One vertex as the block should send it.
    typedef struct {
        logic signed [31:0] vx, vy;
        logic [23:0]        depth;
        logic signed [31:0] sx, sy, ex, ey;
        logic               last, degen;
    } t_vertex;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic [23:0] i_depth_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_vert_x, o_vert_y, o_seg_start_x, o_seg_start_y;
    logic signed [31:0] o_seg_end_x, o_seg_end_y;
    logic [23:0] o_depth_out;
    logic o_last_vertex, o_degenerate;

    thick_line_quad_expander_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_depth_in(i_depth_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_vert_x(o_vert_x), .o_vert_y(o_vert_y), .o_depth_out(o_depth_out),
        .o_seg_start_x(o_seg_start_x), .o_seg_start_y(o_seg_start_y),
        .o_seg_end_x(o_seg_end_x), .o_seg_end_y(o_seg_end_y),
        .o_last_vertex(o_last_vertex), .o_degenerate(o_degenerate)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_segment pending_segs[$];
    t_vertex  expected_verts[$];
    logic [23:0] width_model = 24'd65536;
    int error_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [31:0] clamp32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7fffffff;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Works out the six vertices of one segment and queues them.
    task automatic expand_segment(input t_segment s);
        logic signed [35:0] dx, dy, ox, oy;
        logic signed [35:0] cx[4], cy[4];
        logic [63:0] ax, ay, mag, len, ux, uy, mx, my, halfw;
        int lead, c;
        logic degen;
        t_vertex v;
        int corner_of[6] = '{0, 3, 1, 3, 2, 1};
        dx = 36'(s.ex) - 36'(s.sx);
        dy = 36'(s.ey) - 36'(s.sy);
        degen = (dx == 0) && (dy == 0);
        ox = 0;
        oy = 0;
        if (!degen) begin
            ax = dx < 0 ? 64'(-dx) : 64'(dx);
            ay = dy < 0 ? 64'(-dy) : 64'(dy);
            mag = ax > ay ? ax : ay;
            halfw = 64'(width_model >> 1);
            lead = 63;
            while (lead > 0 && mag[lead] == 1'b0) lead--;
            if (lead > DIR_FRAC) begin
                ax = ax >> (lead - DIR_FRAC);
                ay = ay >> (lead - DIR_FRAC);
            end else if (lead < DIR_FRAC) begin
                ax = ax << (DIR_FRAC - lead);
                ay = ay << (DIR_FRAC - lead);
            end
            len = int_sqrt(ax * ax + ay * ay);
            if (len == 0) len = 1;
            ux = (ax << DIR_FRAC) / len;
            uy = (ay << DIR_FRAC) / len;
            mx = (halfw * ux + (64'd1 << (DIR_FRAC - 1))) >> DIR_FRAC;
            my = (halfw * uy + (64'd1 << (DIR_FRAC - 1))) >> DIR_FRAC;
            ox = dx < 0 ? -36'(mx) : 36'(mx);
            oy = dy < 0 ? -36'(my) : 36'(my);
        end
        cx[0] = 36'(s.sx) - ox + oy;  cy[0] = 36'(s.sy) - oy - ox;
        cx[1] = 36'(s.ex) + ox + oy;  cy[1] = 36'(s.ey) + oy - ox;
        cx[2] = 36'(s.ex) + ox - oy;  cy[2] = 36'(s.ey) + oy + ox;
        cx[3] = 36'(s.sx) - ox - oy;  cy[3] = 36'(s.sy) - oy + ox;
        for (int k = 0; k < NUM_VERTS; k++) begin
            c = corner_of[k];
            v.vx = clamp32(cx[c]);
            v.vy = clamp32(cy[c]);
            v.depth = s.depth;
            v.sx = s.sx; v.sy = s.sy; v.ex = s.ex; v.ey = s.ey;
            v.last = (k == NUM_VERTS - 1);
            v.degen = degen;
            expected_verts.push_back(v);
        end
    endtask

    // Mostly short gaps, now and then a long one, often none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents queued segments with random gaps between them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expand_segment('{i_start_x, i_start_y, i_end_x, i_end_y, i_depth_in});
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0 || pending_segs.size() == 0) begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    t_segment s;
                    s = pending_segs.pop_front();
                    i_valid <= 1'b1;
                    i_start_x <= s.sx; i_start_y <= s.sy;
                    i_end_x <= s.ex; i_end_y <= s.ey;
                    i_depth_in <= s.depth;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // Monitor: checks every accepted vertex against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_verts.size() == 0) begin
                    report_mismatch("unexpected vertex", 64'(o_vert_x), 64'd0);
                end else begin
                    t_vertex w;
                    w = expected_verts.pop_front();
                    if (o_vert_x !== w.vx)
                        report_mismatch("vert_x", 64'(o_vert_x), 64'(w.vx));
                    if (o_vert_y !== w.vy)
                        report_mismatch("vert_y", 64'(o_vert_y), 64'(w.vy));
                    if (o_depth_out !== w.depth)
                        report_mismatch("depth", 64'(o_depth_out), 64'(w.depth));
                    if (o_seg_start_x !== w.sx)
                        report_mismatch("start_x", 64'(o_seg_start_x), 64'(w.sx));
                    if (o_seg_start_y !== w.sy)
                        report_mismatch("start_y", 64'(o_seg_start_y), 64'(w.sy));
                    if (o_seg_end_x !== w.ex)
                        report_mismatch("end_x", 64'(o_seg_end_x), 64'(w.ex));
                    if (o_seg_end_y !== w.ey)
                        report_mismatch("end_y", 64'(o_seg_end_y), 64'(w.ey));
                    if (o_last_vertex !== w.last)
                        report_mismatch("last", 64'(o_last_vertex), 64'(w.last));
                    if (o_degenerate !== w.degen)
                        report_mismatch("degenerate", 64'(o_degenerate), 64'(w.degen));
                end
            end
            if (recv_gap > 0) begin
                i_ready <= 1'b0;
                recv_gap--;
            end else begin
                i_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $signed(32'($urandom_range(0, 20'hFFFFF))) - 32'sd524288;
        if (r < 7) return $signed($urandom());
        if (r == 7) return 32'sh7fffffff - $urandom_range(0, 5000);
        return 32'sh80000000 + $urandom_range(0, 5000);
    endfunction

    task automatic queue_segment(input logic signed [31:0] sx, sy, ex, ey,
                                 input logic [23:0] depth);
        pending_segs.push_back('{sx, sy, ex, ey, depth});
    endtask

    // Waits until every queued segment has been sent and all its expected vertices checked.
    task automatic wait_drained();
        while (pending_segs.size() != 0 || i_valid || expected_verts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the width register while the block is idle.
    task automatic set_width(input logic [23:0] w);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_model = w;
    endtask

    task automatic queue_random(input int count);
        logic signed [31:0] sx, sy;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord();
            sy = rand_coord();
            case ($urandom_range(0, 9))
                0: queue_segment(sx, sy, sx, sy, 24'($urandom()));
                1: queue_segment(sx, sy, sx, rand_coord(), 24'($urandom()));
                2: queue_segment(sx, sy, rand_coord(), sy, 24'($urandom()));
                3: queue_segment(sx, sy, sx + $signed(32'($urandom_range(0, 3))) - 1,
                                 sy + $signed(32'($urandom_range(0, 3))) - 1,
                                 24'($urandom()));
                default: queue_segment(sx, sy, rand_coord(), rand_coord(), 24'($urandom()));
            endcase
        end
    endtask

    initial begin
        logic [23:0] widths[6] = '{24'd0, 24'd1, 24'hFFFFFF, 24'd131072, 24'd65536, 24'd7};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero length, axis-aligned, diagonal, field extremes, saturation.
        queue_segment(0, 0, 0, 0, 24'd0);
        queue_segment(32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00020000, 24'hFFFFFF);
        queue_segment(0, 0, 32'sh000a0000, 0, 24'd5);
        queue_segment(0, 0, 0, -32'sh000a0000, 24'd6);
        queue_segment(0, 0, 32'sh00050000, 32'sh00050000, 24'd7);
        queue_segment(0, 0, -32'sh00030000, 32'sh00040000, 24'd8);
        queue_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 24'hAAAAAA);
        queue_segment(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 24'h555555);
        queue_segment(32'sh7fffffff, 0, 32'sh7ffffff0, 0, 24'd1);
        queue_segment(0, 32'sh80000000, 0, 32'sh80000010, 24'd2);
        queue_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 24'd3);
        queue_segment(0, 0, 1, 0, 24'd4);
        queue_segment(0, 0, 1, 1, 24'd9);
        queue_segment(32'shFFFFFFFF, 32'shFFFFFFFF, 0, 0, 24'd10);
        wait_drained();
        set_width(24'hFFFFFF);
        queue_segment(32'sh7fff0000, 0, 32'sh7fffff00, 32'sh100, 24'd11);
        queue_segment(0, 0, 32'sh00010000, 32'sh00030000, 24'd12);
        queue_segment(5, 5, 5, 5, 24'd13);
        wait_drained();

        // Random phases, each under a different stroke width.
        foreach (widths[i]) begin
            set_width(i == 5 ? 24'($urandom()) : widths[i]);
            queue_random(65);
            wait_drained();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
